// ----- design/tcd_pkg.sv -----
package tcd_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [15:0] HOLD_DEFAULT    = 16'd650;
	localparam logic [15:0] NAV_DEFAULT     = 16'd220;
	localparam logic [15:0] CONFIRM_DEFAULT = 16'd520;
	localparam logic [7:0]  BIT_A_DEFAULT   = 8'd1;
	localparam logic [7:0]  BIT_B_DEFAULT   = 8'd2;
	localparam logic [7:0]  BIT_C_DEFAULT   = 8'd4;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_A    = 3'd1,
		EV_B    = 3'd2,
		EV_C    = 3'd3,
		EV_AC   = 3'd4,
		EV_WAKE = 3'd5,
		EV_MENU = 3'd6
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_THRESHOLD    = 3'd0,
		CFG_NAV_PULSE_LEN     = 3'd1,
		CFG_CONFIRM_PULSE_LEN = 3'd2,
		CFG_FEEDBACK_ENABLED  = 3'd3,
		CFG_BIT_A             = 3'd4,
		CFG_BIT_B             = 3'd5,
		CFG_BIT_C             = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic        key_a;
		logic        key_b;
		logic        suppress_req;
		logic        inject_valid;
		logic [7:0]  inject_mask;
		logic [31:0] inject_duration;
	} tick_t;

	typedef struct packed {
		logic        event_valid;
		logic [2:0]  event_code;
		logic        tone_request;
		logic [7:0]  out_mask;
		logic        any_pressed;
		logic [31:0] event_seq;
		logic [31:0] event_age;
		logic [31:0] activity_age;
	} result_t;

endpackage

// ----- design/tcd_stream_if.sv -----
interface tcd_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/two_key_click_hold_chord_decoder.sv -----
// Two-key click / hold / chord decoder.
// ticks   : sink channel, one word per millisecond tick carrying both key
//           levels plus suppress and mask-injection requests.
// results : source channel, one word per accepted tick with the event flag,
//           last event code, tone request, output mask, activity flag,
//           event count and the event and activity ages in ms.
// cfg_*   : register write port; the user must write it only while the block
//           is idle, and the block itself does not enforce this.
// A tick lands in an input register, and the decode logic feeds the result
// register from it. One tick is accepted every cycle unless the result is
// stalled; the key state updates in the same cycle that the result register
// loads, so consecutive ticks need no spacing.
// When the receiver stalls, the result register holds its word; the input
// register takes one more tick only if it is empty, then ticks.ready drops.
// Reset clears all tracking state, sets the millisecond counter to one and
// loads register defaults: hold 650 ms, pulses 220 and 520 ms, tone on,
// button masks 1, 2 and 4.
module two_key_click_hold_chord_decoder
	import tcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tcd_stream_if.sink            ticks,
	tcd_stream_if.source          results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [15:0] hold_q, nav_q, confirm_q;
	logic        fb_q;
	logic [7:0]  bit_a_q, bit_b_q, bit_c_q;

	logic        s1_valid_q;
	tick_t       word_s1;
	logic        out_valid_q;
	result_t     out_q;
	logic        adv;
	logic        step;

	logic [31:0] tick_q;
	logic        prev_a_q, prev_b_q;
	logic [31:0] down_a_q, down_b_q;
	logic [7:0]  pm_q;
	logic [31:0] pdl_q;
	logic [7:0]  im_q;
	logic [31:0] idl_q;
	logic        chord_q;
	logic [7:0]  cm_q;
	logic        supp_q;
	ev_t         ev_q;
	logic [31:0] evt_q, act_q, seq_q;

	logic [31:0] n_down_a, n_down_b, n_pdl, n_idl, n_evt, n_act, n_seq;
	logic [7:0]  n_pm, n_im, n_cm;
	logic        n_chord, n_supp;
	ev_t         n_ev;
	result_t     res;

	function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
		logic [31:0] diff;
		diff = now - dl;
		return !diff[31];
	endfunction

	assign adv           = !out_valid_q || results.ready;
	assign ticks.ready   = !s1_valid_q || adv;
	assign step          = s1_valid_q && adv;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= HOLD_DEFAULT;
			nav_q     <= NAV_DEFAULT;
			confirm_q <= CONFIRM_DEFAULT;
			fb_q      <= 1'b1;
			bit_a_q   <= BIT_A_DEFAULT;
			bit_b_q   <= BIT_B_DEFAULT;
			bit_c_q   <= BIT_C_DEFAULT;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HOLD_THRESHOLD:    hold_q    <= cfg_data[15:0];
				CFG_NAV_PULSE_LEN:     nav_q     <= cfg_data[15:0];
				CFG_CONFIRM_PULSE_LEN: confirm_q <= cfg_data[15:0];
				CFG_FEEDBACK_ENABLED:  fb_q      <= cfg_data[0];
				CFG_BIT_A:             bit_a_q   <= cfg_data[7:0];
				CFG_BIT_B:             bit_b_q   <= cfg_data[7:0];
				CFG_BIT_C:             bit_c_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic        ka, kb, pub, b_first;
		logic [31:0] now, d;
		logic [7:0]  held;

		ka       = word_s1.key_a;
		kb       = word_s1.key_b;
		now      = tick_q;
		pub      = 1'b0;
		b_first  = 1'b0;
		d        = '0;
		held     = '0;
		n_supp   = supp_q;
		n_pm     = pm_q;
		n_pdl    = pdl_q;
		n_im     = im_q;
		n_idl    = idl_q;
		n_act    = act_q;
		n_down_a = down_a_q;
		n_down_b = down_b_q;
		n_chord  = chord_q;
		n_cm     = cm_q;
		n_ev     = ev_q;
		n_evt    = evt_q;
		n_seq    = seq_q;

		if (word_s1.suppress_req) begin
			n_supp = 1'b1;
			n_pm   = '0;
			n_pdl  = '0;
		end
		if (word_s1.inject_valid) begin
			if (word_s1.inject_mask == '0 || word_s1.inject_duration == '0) begin
				n_im  = '0;
				n_idl = '0;
			end else begin
				n_im  = word_s1.inject_mask;
				n_idl = now + word_s1.inject_duration;
				n_act = now;
			end
		end
		if (n_im != '0 && reached(now, n_idl)) begin
			n_im  = '0;
			n_idl = '0;
		end
		if (ka != prev_a_q || kb != prev_b_q)
			n_act = now;
		if (ka && !prev_a_q)
			n_down_a = now;
		if (kb && !prev_b_q)
			n_down_b = now;

		if (n_supp) begin
			n_pm  = '0;
			n_pdl = '0;
			if (!ka && !kb)
				n_supp = 1'b0;
		end else begin
			if (ka && kb && !n_chord) begin
				d       = n_down_a - n_down_b;
				b_first = n_down_a != '0 && n_down_b != '0 && d != '0 && !d[31];
				n_chord = 1'b1;
				n_cm    = b_first ? (bit_a_q | bit_c_q) : bit_c_q;
				n_pm    = '0;
				n_pdl   = '0;
				n_ev    = b_first ? EV_AC : EV_C;
				n_evt   = now;
				n_act   = now;
				n_seq   = n_seq + 32'd1;
				pub     = 1'b1;
			end
			if (n_chord) begin
				held = (ka && kb) ? n_cm : '0;
				if (!ka && !kb) begin
					n_chord = 1'b0;
					n_cm    = '0;
				end
			end else begin
				if (!ka && prev_a_q) begin
					if (now - n_down_a >= {16'b0, hold_q}) begin
						n_ev = EV_MENU;
					end else begin
						n_ev  = EV_A;
						n_pm  = bit_a_q;
						n_pdl = now + {16'b0, nav_q};
					end
					n_evt = now;
					n_act = now;
					n_seq = n_seq + 32'd1;
					pub   = 1'b1;
				end
				if (!kb && prev_b_q) begin
					if (now - n_down_b >= {16'b0, hold_q}) begin
						n_ev = EV_WAKE;
					end else begin
						n_ev  = EV_B;
						n_pm  = bit_b_q;
						n_pdl = now + {16'b0, confirm_q};
					end
					n_evt = now;
					n_act = now;
					n_seq = n_seq + 32'd1;
					pub   = 1'b1;
				end
				if (n_pm == '0 || reached(now, n_pdl)) begin
					n_pm  = '0;
					n_pdl = '0;
					held  = '0;
				end else begin
					held = n_pm;
				end
			end
		end

		res.event_valid  = pub;
		res.event_code   = n_ev;
		res.tone_request = pub && fb_q;
		res.out_mask     = (n_im != '0) ? n_im : held;
		res.any_pressed  = n_im != '0 || n_pm != '0 || ka || kb;
		res.event_seq    = n_seq;
		res.event_age    = (n_ev == EV_NONE) ? '1 : now - n_evt;
		res.activity_age = now - n_act;
	end

	always_ff @(posedge clk) begin
		if (ticks.ready)
			word_s1 <= ticks.data;
		if (step)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			tick_q      <= 32'd1;
			prev_a_q    <= 1'b0;
			prev_b_q    <= 1'b0;
			down_a_q    <= '0;
			down_b_q    <= '0;
			pm_q        <= '0;
			pdl_q       <= '0;
			im_q        <= '0;
			idl_q       <= '0;
			chord_q     <= 1'b0;
			cm_q        <= '0;
			supp_q      <= 1'b0;
			ev_q        <= EV_NONE;
			evt_q       <= '0;
			act_q       <= '0;
			seq_q       <= '0;
		end else begin
			if (ticks.ready)
				s1_valid_q <= ticks.valid;
			if (adv)
				out_valid_q <= s1_valid_q;
			if (step) begin
				tick_q   <= tick_q + 32'd1;
				prev_a_q <= word_s1.key_a;
				prev_b_q <= word_s1.key_b;
				down_a_q <= n_down_a;
				down_b_q <= n_down_b;
				pm_q     <= n_pm;
				pdl_q    <= n_pdl;
				im_q     <= n_im;
				idl_q    <= n_idl;
				chord_q  <= n_chord;
				cm_q     <= n_cm;
				supp_q   <= n_supp;
				ev_q     <= n_ev;
				evt_q    <= n_evt;
				act_q    <= n_act;
				seq_q    <= n_seq;
			end
		end
	end

endmodule

// ----- design/tcd_checker.sv -----
module tcd_checker
	import tcd_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result word changed while stalled");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.event_valid |-> res_data.event_code != EV_NONE)
		else $error("event published with no event code");

	a_tone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.tone_request |-> res_data.event_valid)
		else $error("tone request without event");

	a_age_none: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.event_code == EV_NONE |-> res_data.event_age == '1)
		else $error("event age not saturated before first event");

endmodule

bind two_key_click_hold_chord_decoder tcd_checker u_tcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data)
);
